>>> hdl/ipv4_header_parse_check_macros.svh
// Assertion macros shared by the IPv4 header parser RTL.
`ifndef IPV4_HEADER_PARSE_CHECK_MACROS_SVH
`define IPV4_HEADER_PARSE_CHECK_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/ihp_pkg.sv
// Types and constants for the IPv4 header parser.
`timescale 1ns / 1ps
package ihp_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_SHORT_IHL   = 3'd2,
    ST_RSVD_FLAG   = 3'd3,
    ST_DF_AND_MF   = 3'd4,
    ST_TTL_ZERO    = 3'd5
  } ihp_status_t;

  localparam int unsigned HDR_BYTES   = 20;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned OUT_DATA_W  = 160;
  localparam int unsigned OUT_USER_W  = 4;

  localparam logic [POS_W-1:0] POS_VER_IHL = 5'd0;
  localparam logic [POS_W-1:0] POS_FLAGS   = 5'd6;
  localparam logic [POS_W-1:0] POS_TTL     = 5'd8;
  localparam logic [POS_W-1:0] POS_TAIL    = 5'd12;
  localparam logic [POS_W-1:0] POS_LAST    = 5'(HDR_BYTES - 1);

  localparam logic [3:0]  IP_VERSION   = 4'd4;
  localparam logic [3:0]  IHL_MIN      = 4'd5;
  localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

endpackage

>>> hdl/ipv4_header_parse_check.sv
// IPv4 header parser with a check of the header checksum.
// One header byte is taken per transfer on the in_ channel (in_tuser marks byte 0 of
// a header), and the block accepts a byte in every cycle unless stalled as told below.
// Each byte goes from an input register through one short update of the byte index,
// the 16-bit ones'-complement sum (full end-around carry) and the field shift stores
// into the result register, so a result is loaded straight from the byte that causes
// it, and the sustained rate is one byte per cycle while no stall holds; a result
// waiting on out_tready stalls the input only when the next byte also produces a result.
// A bad version, IHL under 5, the reserved flag, DF with MF, or TTL zero ends the header
// at that byte with a fault status and all other fields zero; otherwise byte 19 gives
// every fixed field and the checksum flag. Option bytes and bytes outside a header
// are dropped, and a start flag inside a header abandons it without a result.
`timescale 1ns / 1ps
`include "ipv4_header_parse_check_macros.svh"
module ipv4_header_parse_check (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  logic                               in_tuser,   // [0] first_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [3:0] header_words, [11:4] service_byte, [27:12] total_length, [43:28] ident,
  // [58:44] flags_fragment, [66:59] hop_limit, [74:67] next_protocol,
  // [90:75] header_checksum, [122:91] source_address,
  // [154:123] destination_address, [159:155] zero
  output logic [ihp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [ihp_pkg::OUT_USER_W-1:0]     out_tuser   // [2:0] status, [3] checksum_ok
);
  import ihp_pkg::*;

  // input stage
  logic             stage_v_r;
  logic [7:0]       byte_r;
  logic             first_r;

  // parser state
  logic             active_r, active_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [63:0]      field_r, field_nxt;
  logic [31:0]      tail_r, tail_nxt;
  logic [63:0]      addr_r, addr_nxt;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic             act;
  logic [POS_W-1:0] pos;
  logic [15:0]      sum_cur;
  logic [7:0]       pend_cur;
  logic [63:0]      field_cur;
  logic [31:0]      tail_cur;
  logic [63:0]      addr_cur;
  logic [16:0]      sum_wide;
  logic [15:0]      sum_fold;
  logic             is_fault;
  logic             has_res;
  ihp_status_t      status;
  logic             out_free;
  logic             stage_go;

  always_comb begin
    // a start flag acts on cleared state
    act       = first_r | active_r;
    pos       = first_r ? '0 : pos_r;
    sum_cur   = first_r ? '0 : sum_r;
    pend_cur  = first_r ? '0 : pend_r;
    field_cur = first_r ? '0 : field_r;
    tail_cur  = first_r ? '0 : tail_r;
    addr_cur  = first_r ? '0 : addr_r;

    sum_wide = {1'b0, sum_cur} + {1'b0, pend_cur, byte_r};
    sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

    pend_nxt  = pos[0] ? pend_cur : byte_r;
    sum_nxt   = pos[0] ? sum_fold : sum_cur;
    field_nxt = field_cur;
    tail_nxt  = tail_cur;
    addr_nxt  = addr_cur;
    if (pos < POS_TTL) begin
      field_nxt = {field_cur[55:0], byte_r};
    end else if (pos < POS_TAIL) begin
      tail_nxt = {tail_cur[23:0], byte_r};
    end else begin
      addr_nxt = {addr_cur[55:0], byte_r};
    end

    status = ST_OK;
    if (pos == POS_VER_IHL) begin
      priority if (byte_r[7:4] != IP_VERSION) status = ST_BAD_VERSION;
      else if (byte_r[3:0] < IHL_MIN)          status = ST_SHORT_IHL;
      else                                     status = ST_OK;
    end else if (pos == POS_FLAGS) begin
      priority if (byte_r[7])                  status = ST_RSVD_FLAG;
      else if (byte_r[6] && byte_r[5])         status = ST_DF_AND_MF;
      else                                     status = ST_OK;
    end else if (pos == POS_TTL) begin
      if (byte_r == 8'd0) status = ST_TTL_ZERO;
    end
    is_fault = (status != ST_OK);
    has_res  = act && (is_fault || pos >= POS_LAST);

    out_free = !out_valid_r || out_tready;
    stage_go = stage_v_r && (!has_res || out_free);
    in_tready = !stage_v_r || stage_go;

    active_nxt = active_r;
    pos_nxt    = pos_r;
    if (act) begin
      active_nxt = !has_res;
      if (is_fault) begin
        pos_nxt = pos;
      end else if (has_res) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos + 1'b1;
      end
    end

    out_data_nxt = '0;
    out_user_nxt = {1'b0, status};
    if (!is_fault) begin
      out_user_nxt[3] = (sum_fold == SUM_ALL_ONES);
      out_data_nxt = {5'd0, addr_nxt[31:0], addr_nxt[63:32], tail_cur[15:0],
                      tail_cur[23:16], tail_cur[31:24], field_cur[14:0],
                      field_cur[31:16], field_cur[47:32], field_cur[55:48],
                      field_cur[59:56]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (in_tready) stage_v_r <= in_tvalid;
      if (stage_go && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (stage_go) begin
        active_r <= active_nxt;
        pos_r    <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r  <= in_tdata;
      first_r <= in_tuser;
    end
    if (stage_go && act) begin
      sum_r   <= sum_nxt;
      pend_r  <= pend_nxt;
      field_r <= field_nxt;
      tail_r  <= tail_nxt;
      addr_r  <= addr_nxt;
    end
    if (stage_go && has_res) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `IHP_ASSERT_IMP(a_fault_clears_fields,
    out_valid_r && out_user_r[2:0] != ST_OK, out_data_r == '0 && !out_user_r[3])
  `IHP_ASSERT_IMP(a_pos_in_range, 1'b1, pos_r <= POS_LAST)
  `IHP_ASSERT_NEXT(a_result_loaded, stage_go && has_res, out_valid_r)
  `IHP_ASSERT_NEXT(a_held_stage, stage_v_r && !stage_go, stage_v_r && $stable(byte_r))

endmodule
